/* rtl/slrp_pkg.sv */
package slrp_pkg;

	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	localparam int LEN_NOTFOUND = 8;
	localparam int LEN_SUCCESS  = 7;
	localparam int LEN_INVALID  = 15;

	// Zero bits above the result fields in the output tdata.
	localparam int OUT_PAD_W = 4;

	typedef enum logic [1:0] {
		FUNC_REQUEST = 2'd0,
		FUNC_BYTE    = 2'd1,
		FUNC_LINKERR = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_SUCCESS  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_INVALID  = 3'd3,
		ST_UNKNOWN  = 3'd4,
		ST_ERROR    = 3'd5
	} reply_status_t;

	typedef enum logic [2:0] {
		PH_READY,
		PH_HEADER,
		PH_DATA,
		PH_ERROR,
		PH_PASS,
		PH_DOT
	} phase_t;

	// What an accepted word produces on the output side.
	typedef enum logic [2:0] {
		PLAN_NONE,
		PLAN_ONE,
		PLAN_NL_BYTE,
		PLAN_REPLAY,
		PLAN_REPLAY_BYTE
	} plan_t;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_IN,
		SRC_NL,
		SRC_MEM,
		SRC_EXTRA
	} src_t;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_READ,
		SEQ_PUSH,
		SEQ_EXTRA
	} seq_t;

	typedef struct packed {
		logic accept;
		logic push;
		src_t src;
		logic last;
		logic rd;
		logic step;
	} cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  out_valid;
		logic  rpl_last;
		logic  rpl_tail;
	} stat_t;

	function automatic logic [7:0] notfound_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = "N";
			4'd1: c = "O";
			4'd2: c = "T";
			4'd3: c = "F";
			4'd4: c = "O";
			4'd5: c = "U";
			4'd6: c = "N";
			4'd7: c = "D";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] success_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = "S";
			4'd1: c = "U";
			4'd2: c = "C";
			4'd3: c = "C";
			4'd4: c = "E";
			4'd5: c = "S";
			4'd6: c = "S";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] invalid_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0:  c = "i";
			4'd1:  c = "n";
			4'd2:  c = "v";
			4'd3:  c = "a";
			4'd4:  c = "l";
			4'd5:  c = "i";
			4'd6:  c = "d";
			4'd7:  c = " ";
			4'd8:  c = "c";
			4'd9:  c = "o";
			4'd10: c = "m";
			4'd11: c = "m";
			4'd12: c = "a";
			4'd13: c = "n";
			4'd14: c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* rtl/status_line_dot_stuffed_reply_parser.sv */
// A result appears in the cycle after its word is accepted; a status line replayed from
// the line buffer is first read into a register, then pushed to the output register.
// One word per cycle while the output is free; a data byte that needs a separator holds
// the input until both are out, and an unknown or overlong status line reads and outputs
// each buffered byte in turn, plus the overflowing byte, before the next word is taken.
// Reset (arst_n low, asynchronous): ready, status pending, output empty; buffer kept.
module status_line_dot_stuffed_reply_parser #(
	parameter int HEADER_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,  // [1:0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [10:8] status, [11] done_res
	output logic        m_axis_tuser,  // [0] data_valid
	output logic        m_axis_tlast
);
	import slrp_pkg::*;

	cmd_t       cmd;
	stat_t      stat;
	logic [7:0] out_byte;
	logic [2:0] out_status;
	logic       out_done;

	slrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.in_ready  (s_axis_tready),
		.cmd       (cmd)
	);

	slrp_dp #(
		.HEADER_MAX (HEADER_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_func    (s_axis_tuser),
		.in_byte    (s_axis_tdata),
		.out_ready  (m_axis_tready),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_dv     (m_axis_tuser),
		.out_byte   (out_byte),
		.out_status (out_status),
		.out_done   (out_done),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_done, out_status, out_byte};

	// A new word is pushed only into an empty or departing output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output word overwritten before it was taken");

	// Input is taken only when no earlier word still has results to come.
	a_input_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!m_axis_tvalid || m_axis_tlast))
		else $error("input accepted while results of a previous word are pending");

	// A word without data is always the single, final result of its input.
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
		else $error("result without data is not a lone final word");

	// Replay reads are never issued in the cycle an input word is taken.
	a_read_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(s_axis_tvalid && s_axis_tready))
		else $error("buffer read overlaps input acceptance");

endmodule

/* rtl/slrp_dp.sv */
module slrp_dp #(
	parameter int HEADER_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        in_func,
	input  logic [7:0]        in_byte,
	input  logic              out_ready,
	input  slrp_pkg::cmd_t    cmd,
	output slrp_pkg::stat_t   stat,
	output logic              out_valid,
	output logic              out_dv,
	output logic [7:0]        out_byte,
	output logic [2:0]        out_status,
	output logic              out_done,
	output logic              out_last
);
	import slrp_pkg::*;

	localparam int CW = $clog2(HEADER_MAX + 1);
	localparam int AW = $clog2(HEADER_MAX);

	phase_t        phase_q, phase_d;
	reply_status_t status_q, status_d;
	logic [CW-1:0] count_q, count_d;
	logic          data_seen_q, data_seen_d;
	logic          at_ls_q, at_ls_d;
	logic          m_nf_q, m_nf_d, m_sc_q, m_sc_d, m_iv_q, m_iv_d;
	logic [CW-1:0] len_q, idx_q;
	logic          tail_q;
	logic [7:0]    extra_q, rdata_q;
	logic [7:0]    mem [HEADER_MAX];
	logic          hdr_wr;
	plan_t         plan;
	func_t         func;
	logic          is_nl, is_dot, hdr_full, hdr_nf, hdr_sc, hdr_iv, done_d;

	logic          out_valid_q, out_dv_q, out_done_q, out_last_q;
	logic [7:0]    out_byte_q;
	logic [2:0]    out_status_q;

	assign func     = func_t'(in_func);
	assign is_nl    = (in_byte == CHAR_NL);
	assign is_dot   = (in_byte == CHAR_DOT);
	assign hdr_full = (count_q >= CW'(HEADER_MAX));
	assign hdr_nf   = m_nf_q && (count_q == CW'(LEN_NOTFOUND));
	assign hdr_sc   = m_sc_q && (count_q == CW'(LEN_SUCCESS));
	assign hdr_iv   = m_iv_q && (count_q == CW'(LEN_INVALID));

	// Parse phase transitions.
	always_comb begin
		phase_d = phase_q;
		if (cmd.accept) begin
			unique case (func)
				FUNC_REQUEST: phase_d = PH_HEADER;
				FUNC_LINKERR: phase_d = PH_ERROR;
				FUNC_BYTE: begin
					unique case (phase_q)
						PH_HEADER: begin
							if (is_nl) begin
								phase_d = hdr_sc ? PH_DATA : PH_READY;
							end else if (hdr_full) begin
								phase_d = PH_PASS;
							end
						end
						PH_PASS: begin
							if (is_nl) phase_d = PH_READY;
						end
						PH_DATA: begin
							if (at_ls_q && is_dot) phase_d = PH_DOT;
						end
						PH_DOT: phase_d = is_nl ? PH_READY : PH_DATA;
						default: phase_d = phase_q;
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Emission plan and the remaining parse state.
	always_comb begin
		plan        = PLAN_NONE;
		hdr_wr      = 1'b0;
		status_d    = status_q;
		count_d     = count_q;
		data_seen_d = data_seen_q;
		at_ls_d     = at_ls_q;
		m_nf_d      = m_nf_q;
		m_sc_d      = m_sc_q;
		m_iv_d      = m_iv_q;
		unique case (func)
			FUNC_REQUEST: begin
				status_d    = ST_PENDING;
				count_d     = '0;
				data_seen_d = 1'b0;
				at_ls_d     = 1'b1;
				m_nf_d      = 1'b1;
				m_sc_d      = 1'b1;
				m_iv_d      = 1'b1;
			end
			FUNC_LINKERR: status_d = ST_ERROR;
			FUNC_BYTE: begin
				unique case (phase_q)
					PH_HEADER: begin
						if (is_nl) begin
							count_d = '0;
							if (hdr_nf) begin
								status_d = ST_NOTFOUND;
							end else if (hdr_sc) begin
								status_d    = ST_SUCCESS;
								at_ls_d     = 1'b1;
								data_seen_d = 1'b0;
							end else if (hdr_iv) begin
								status_d = ST_INVALID;
							end else begin
								status_d = ST_UNKNOWN;
								plan     = (count_q == '0) ? PLAN_NONE : PLAN_REPLAY;
							end
						end else if (!hdr_full) begin
							hdr_wr  = 1'b1;
							count_d = count_q + CW'(1);
							m_nf_d  = m_nf_q && (count_q < CW'(LEN_NOTFOUND)) &&
								(in_byte == notfound_char(count_q[3:0]));
							m_sc_d  = m_sc_q && (count_q < CW'(LEN_SUCCESS)) &&
								(in_byte == success_char(count_q[3:0]));
							m_iv_d  = m_iv_q && (count_q < CW'(LEN_INVALID)) &&
								(in_byte == invalid_char(count_q[3:0]));
						end else begin
							plan        = PLAN_REPLAY_BYTE;
							count_d     = '0;
							data_seen_d = 1'b1;
						end
					end
					PH_PASS: begin
						if (is_nl) status_d = ST_UNKNOWN;
						else plan = PLAN_ONE;
					end
					PH_DATA: begin
						if (at_ls_q) begin
							if (is_nl) begin
								// An empty line still yields a separator once data exists.
								plan = data_seen_q ? PLAN_ONE : PLAN_NONE;
							end else if (!is_dot) begin
								plan        = data_seen_q ? PLAN_NL_BYTE : PLAN_ONE;
								data_seen_d = 1'b1;
								at_ls_d     = 1'b0;
							end
						end else if (is_nl) begin
							at_ls_d = 1'b1;
						end else begin
							plan = PLAN_ONE;
						end
					end
					PH_DOT: begin
						if (is_nl) begin
							at_ls_d = 1'b1;
						end else begin
							plan        = data_seen_q ? PLAN_NL_BYTE : PLAN_ONE;
							data_seen_d = 1'b1;
							at_ls_d     = 1'b0;
						end
					end
					default: plan = PLAN_NONE;
				endcase
			end
			default: plan = PLAN_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_READY;
			status_q    <= ST_PENDING;
			count_q     <= '0;
			data_seen_q <= 1'b0;
			at_ls_q     <= 1'b1;
			m_nf_q      <= 1'b1;
			m_sc_q      <= 1'b1;
			m_iv_q      <= 1'b1;
			len_q       <= '0;
			idx_q       <= '0;
			tail_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				phase_q     <= phase_d;
				status_q    <= status_d;
				count_q     <= count_d;
				data_seen_q <= data_seen_d;
				at_ls_q     <= at_ls_d;
				m_nf_q      <= m_nf_d;
				m_sc_q      <= m_sc_d;
				m_iv_q      <= m_iv_d;
				len_q       <= (plan == PLAN_REPLAY_BYTE) ? CW'(HEADER_MAX) : count_q;
				idx_q       <= '0;
				tail_q      <= (plan == PLAN_REPLAY_BYTE);
			end else if (cmd.step) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) extra_q <= in_byte;
	end

	// Status line buffer.
	always_ff @(posedge clk) begin
		if (cmd.accept && hdr_wr) mem[count_q[AW-1:0]] <= in_byte;
		if (cmd.rd) rdata_q <= mem[idx_q[AW-1:0]];
	end

	// Every pushed word carries the state left by the whole input word. Words pushed
	// after the accepting cycle see the stored state, not the word now waiting.
	assign done_d = ((phase_d == PH_READY) || (phase_d == PH_ERROR)) &&
		((cmd.accept ? status_d : status_q) != ST_PENDING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= (cmd.accept ? status_d : status_q);
			out_done_q   <= done_d;
			out_last_q   <= cmd.last;
			case (cmd.src)
				SRC_IN: begin
					out_dv_q   <= 1'b1;
					out_byte_q <= in_byte;
				end
				SRC_NL: begin
					out_dv_q   <= 1'b1;
					out_byte_q <= CHAR_NL;
				end
				SRC_MEM: begin
					out_dv_q   <= 1'b1;
					out_byte_q <= rdata_q;
				end
				SRC_EXTRA: begin
					out_dv_q   <= 1'b1;
					out_byte_q <= extra_q;
				end
				default: begin
					out_dv_q   <= 1'b0;
					out_byte_q <= 8'h00;
				end
			endcase
		end
	end

	assign stat.plan      = plan;
	assign stat.out_valid = out_valid_q;
	assign stat.rpl_last  = ((idx_q + CW'(1)) == len_q);
	assign stat.rpl_tail  = tail_q;

	assign out_valid  = out_valid_q;
	assign out_dv     = out_dv_q;
	assign out_byte   = out_byte_q;
	assign out_status = out_status_q;
	assign out_done   = out_done_q;
	assign out_last   = out_last_q;

endmodule

/* rtl/slrp_ctrl.sv */
module slrp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  slrp_pkg::stat_t stat,
	output logic            in_ready,
	output slrp_pkg::cmd_t  cmd
);
	import slrp_pkg::*;

	seq_t seq_q, seq_d;
	logic slot_free;
	logic accept;

	assign slot_free = !stat.out_valid || out_ready;
	assign accept    = (seq_q == SEQ_RUN) && slot_free && in_valid;

	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_RUN: begin
				if (accept) begin
					unique case (stat.plan)
						PLAN_NL_BYTE:                  seq_d = SEQ_EXTRA;
						PLAN_REPLAY, PLAN_REPLAY_BYTE: seq_d = SEQ_READ;
						default:                       seq_d = SEQ_RUN;
					endcase
				end
			end
			SEQ_READ: seq_d = SEQ_PUSH;
			SEQ_PUSH: begin
				if (slot_free) begin
					if (!stat.rpl_last) seq_d = SEQ_READ;
					else if (stat.rpl_tail) seq_d = SEQ_EXTRA;
					else seq_d = SEQ_RUN;
				end
			end
			SEQ_EXTRA: begin
				if (slot_free) seq_d = SEQ_RUN;
			end
			default: seq_d = SEQ_RUN;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = accept;
		cmd.push   = 1'b0;
		cmd.src    = SRC_NONE;
		cmd.last   = 1'b1;
		cmd.rd     = 1'b0;
		cmd.step   = 1'b0;
		unique case (seq_q)
			SEQ_RUN: begin
				in_ready = slot_free;
				if (accept) begin
					unique case (stat.plan)
						PLAN_NONE: begin
							cmd.push = 1'b1;
							cmd.src  = SRC_NONE;
						end
						PLAN_ONE: begin
							cmd.push = 1'b1;
							cmd.src  = SRC_IN;
						end
						PLAN_NL_BYTE: begin
							cmd.push = 1'b1;
							cmd.src  = SRC_NL;
							cmd.last = 1'b0;
						end
						default: cmd.push = 1'b0;
					endcase
				end
			end
			SEQ_READ: cmd.rd = 1'b1;
			SEQ_PUSH: begin
				cmd.push = slot_free;
				cmd.src  = SRC_MEM;
				cmd.last = stat.rpl_last && !stat.rpl_tail;
				cmd.step = slot_free && !stat.rpl_last;
			end
			SEQ_EXTRA: begin
				cmd.push = slot_free;
				cmd.src  = SRC_EXTRA;
			end
			default: cmd.push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_RUN;
		end else begin
			seq_q <= seq_d;
		end
	end

endmodule
